// File: rtl/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the P6 stream parser
// Result kinds, status codes and the word passed from the parser front end
// to the output back end.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned TokenMax   = 32;
  localparam int unsigned HdrLimit   = 4096;
  localparam int unsigned CmtLimit   = 4096;
  localparam int unsigned DimW       = 13;
  localparam int unsigned TokLenW    = 6;
  localparam int unsigned CntW       = 13;
  localparam int unsigned PixW       = 26;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_HDR_LONG    = 4'd1,
    ST_CMT_LONG    = 4'd2,
    ST_TOK_LONG    = 4'd3,
    ST_INCOMPLETE  = 4'd4,
    ST_NOT_P6      = 4'd5,
    ST_BAD_DIM     = 4'd6,
    ST_BAD_MAXVAL  = 4'd7,
    ST_NO_SEP      = 4'd8,
    ST_LEN_MISMATCH = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_PIXELS = 3'd4,
    PH_FAILED = 3'd5
  } phase_e;

  // One result word: payload fields of one result item.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        pixel_byte;
    logic [DimW-1:0]   image_width;
    logic [DimW-1:0]   image_height;
    status_e           status;
    logic              final_res;
  } res_t;

endpackage : ppm_pkg
`default_nettype wire

// File: rtl/ppm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_front: header parser and byte classifier
// Consumes one byte per cycle while take_i is high and produces up to two result
// words, which it writes into the result queue.
// ----------------------------------------------------------------------------
module ppm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            eof_i,
  output ppm_pkg::res_t        res0_o,
  output logic                 res0_vld_o,
  output ppm_pkg::res_t        res1_o,
  output logic                 res1_vld_o,
  output logic [ppm_pkg::DimW-1:0] width_o,
  output logic [ppm_pkg::DimW-1:0] height_o
);
  import ppm_pkg::*;

  phase_e               phase_q, phase_d;
  logic                 cmt_q, cmt_d;
  logic [TokLenW-1:0]   tlen_q, tlen_d;
  logic                 tmatch_q, tmatch_d;
  logic [DimW-1:0]      acc_q, acc_d;
  logic [CntW-1:0]      hcnt_q, hcnt_d;
  logic [CntW-1:0]      ccnt_q, ccnt_d;
  logic [DimW-1:0]      wid_q, wid_d;
  logic [DimW-1:0]      hgt_q, hgt_d;
  logic [PixW-1:0]      left_q, left_d;
  status_e              err_q, err_d;
  // Pixel count is built from a registered w*h product, then times 3.
  logic                 mul_pend_q, mul_pend_d;
  logic [PixW-1:0]      wh_q, wh_d;

  logic                 space;
  logic [3:0]           digit;
  logic [DimW+3:0]      acc_mul;
  logic [DimW-1:0]      acc_add;
  logic                 tmatch_add;
  logic                 hdr_over;
  status_e              judge;
  status_e              err;
  res_t                 blank;

  function automatic status_e judge_new(phase_e ph, logic tm, logic [TokLenW-1:0] tl,
                                        logic [DimW-1:0] ac);
    status_e r;
    case (ph)
      PH_MAGIC:  r = (tm && tl == TokLenW'(2)) ? ST_OK : ST_NOT_P6;
      PH_MAXVAL: r = (tm && tl == TokLenW'(3)) ? ST_OK : ST_BAD_MAXVAL;
      default:   r = (!tm || ac == '0 || ac > DimW'(MaxDim)) ? ST_BAD_DIM : ST_OK;
    endcase
    return r;
  endfunction

  assign space = (byte_i == 8'd32) || (byte_i >= 8'd9 && byte_i <= 8'd13);
  assign digit = byte_i[3:0];

  // Token character update (add_char).
  always_comb begin
    acc_mul    = {4'd0, acc_q} * (DimW + 4)'(10) + (DimW + 4)'(digit);
    acc_add    = acc_q;
    tmatch_add = tmatch_q;
    case (phase_q)
      PH_MAGIC: begin
        if (!((tlen_q == TokLenW'(0) && byte_i == "P") ||
              (tlen_q == TokLenW'(1) && byte_i == "6"))) tmatch_add = 1'b0;
      end
      PH_MAXVAL: begin
        if (!((tlen_q == TokLenW'(0) && byte_i == "2") ||
              (tlen_q == TokLenW'(1) && byte_i == "5") ||
              (tlen_q == TokLenW'(2) && byte_i == "5"))) tmatch_add = 1'b0;
      end
      default: begin
        if (byte_i >= "0" && byte_i <= "9") begin
          if (acc_mul > (DimW + 4)'(MaxDim)) acc_add = DimW'(MaxDim + 1);
          else acc_add = acc_mul[DimW-1:0];
        end else begin
          tmatch_add = 1'b0;
        end
      end
    endcase
  end

  // Judge of the pending token.
  always_comb begin
    case (phase_q)
      PH_MAGIC:  judge = (tmatch_q && tlen_q == TokLenW'(2)) ? ST_OK : ST_NOT_P6;
      PH_MAXVAL: judge = (tmatch_q && tlen_q == TokLenW'(3)) ? ST_OK : ST_BAD_MAXVAL;
      default:   judge = (!tmatch_q || acc_q == '0 || acc_q > DimW'(MaxDim))
                         ? ST_BAD_DIM : ST_OK;
    endcase
  end

  assign hdr_over = (hcnt_q >= CntW'(HdrLimit));

  always_comb begin
    blank          = '0;
    blank.kind     = KIND_PIXEL;
    blank.status   = ST_OK;
    phase_d    = phase_q;
    cmt_d      = cmt_q;
    tlen_d     = tlen_q;
    tmatch_d   = tmatch_q;
    acc_d      = acc_q;
    hcnt_d     = hcnt_q;
    ccnt_d     = ccnt_q;
    wid_d      = wid_q;
    hgt_d      = hgt_q;
    left_d     = left_q;
    err_d      = err_q;
    mul_pend_d = 1'b0;
    wh_d       = wh_q;
    err        = ST_OK;
    res0_o     = blank;
    res0_vld_o = 1'b0;
    res1_o     = blank;
    res1_vld_o = 1'b0;

    if (mul_pend_q) begin
      left_d = (wh_q << 1) + wh_q;
    end

    if (take_i) begin
      if (phase_q <= PH_MAXVAL) begin
        if (cmt_q) begin
          if (hdr_over) err = ST_HDR_LONG;
          else begin
            hcnt_d = hcnt_q + CntW'(1);
            if (byte_i == 8'h0A) cmt_d = 1'b0;
            else if (ccnt_q == CntW'(CmtLimit)) err = ST_CMT_LONG;
            else ccnt_d = ccnt_q + CntW'(1);
          end
        end else if (tlen_q == '0) begin
          if (hdr_over) err = ST_HDR_LONG;
          else begin
            hcnt_d = hcnt_q + CntW'(1);
            if (byte_i == "#") begin
              cmt_d  = 1'b1;
              ccnt_d = CntW'(1);
            end else if (!space) begin
              acc_d    = acc_add;
              tmatch_d = tmatch_add;
              tlen_d   = tlen_q + TokLenW'(1);
            end
          end
        end else if (space) begin
          if (judge != ST_OK) err = judge;
          else begin
            if (phase_q == PH_WIDTH)  wid_d = acc_q;
            if (phase_q == PH_HEIGHT) hgt_d = acc_q;
            if (phase_q == PH_MAXVAL) begin
              res0_o              = blank;
              res0_o.kind         = KIND_HEADER;
              res0_o.image_width  = wid_q;
              res0_o.image_height = hgt_q;
              res0_vld_o          = 1'b1;
              wh_d                = PixW'(wid_q) * PixW'(hgt_q);
              mul_pend_d          = 1'b1;
              phase_d             = PH_PIXELS;
            end else begin
              phase_d  = phase_e'(phase_q + 3'd1);
              tlen_d   = '0;
              tmatch_d = 1'b1;
              acc_d    = '0;
              if (hdr_over) err = ST_HDR_LONG;
              else hcnt_d = hcnt_q + CntW'(1);
            end
          end
        end else if (tlen_q >= TokLenW'(TokenMax)) begin
          err = ST_TOK_LONG;
        end else if (hdr_over) begin
          err = ST_HDR_LONG;
        end else begin
          hcnt_d   = hcnt_q + CntW'(1);
          acc_d    = acc_add;
          tmatch_d = tmatch_add;
          tlen_d   = tlen_q + TokLenW'(1);
        end
      end else if (phase_q == PH_PIXELS) begin
        // The count is written from the registered product in the cycle after the
        // header; a byte in that cycle sees it as w*h*3 through the pending product.
        if (mul_pend_q ? (wh_q != '0) : (left_q != '0)) begin
          res0_o            = blank;
          res0_o.pixel_byte = byte_i;
          res0_vld_o        = 1'b1;
          left_d = (mul_pend_q ? ((wh_q << 1) + wh_q) : left_q) - PixW'(1);
        end else begin
          err = ST_LEN_MISMATCH;
        end
      end

      if (err != ST_OK) begin
        err_d   = err;
        phase_d = PH_FAILED;
      end

      if (eof_i) begin
        if (phase_d <= PH_MAXVAL) begin
          // An error above would have set the failed phase, so the token
          // state here is the untouched state from before this byte or the
          // state it just built; judge the pending token from the new state.
          err_d = ST_INCOMPLETE;
          if (tlen_d != '0 && !cmt_d) begin
            if (judge_new(phase_d, tmatch_d, tlen_d, acc_d) != ST_OK)
              err_d = judge_new(phase_d, tmatch_d, tlen_d, acc_d);
            else if (phase_d == PH_MAXVAL) err_d = ST_NO_SEP;
          end
        end else if (phase_d == PH_PIXELS && left_d != '0) begin
          err_d = ST_LEN_MISMATCH;
        end else if (phase_d == PH_PIXELS && mul_pend_d && wh_d != '0) begin
          err_d = ST_LEN_MISMATCH;
        end
        res1_o           = blank;
        res1_o.kind      = KIND_STATUS;
        res1_o.status    = err_d;
        res1_o.final_res = 1'b1;
        res1_vld_o       = 1'b1;
        phase_d    = PH_MAGIC;
        cmt_d      = 1'b0;
        tlen_d     = '0;
        tmatch_d   = 1'b1;
        acc_d      = '0;
        hcnt_d     = '0;
        ccnt_d     = '0;
        wid_d      = '0;
        hgt_d      = '0;
        left_d     = '0;
        err_d      = ST_OK;
        mul_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      cmt_q      <= 1'b0;
      tlen_q     <= '0;
      tmatch_q   <= 1'b1;
      acc_q      <= '0;
      hcnt_q     <= '0;
      ccnt_q     <= '0;
      wid_q      <= '0;
      hgt_q      <= '0;
      left_q     <= '0;
      err_q      <= ST_OK;
      mul_pend_q <= 1'b0;
      wh_q       <= '0;
    end else begin
      phase_q    <= phase_d;
      cmt_q      <= cmt_d;
      tlen_q     <= tlen_d;
      tmatch_q   <= tmatch_d;
      acc_q      <= acc_d;
      hcnt_q     <= hcnt_d;
      ccnt_q     <= ccnt_d;
      wid_q      <= wid_d;
      hgt_q      <= hgt_d;
      left_q     <= left_d;
      err_q      <= err_d;
      mul_pend_q <= mul_pend_d;
      wh_q       <= wh_d;
    end
  end

  assign width_o  = wid_q;
  assign height_o = hgt_q;

endmodule : ppm_front
`default_nettype wire

// File: rtl/ppm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_queue: result queue between parser and output port
// Takes up to two words per cycle and hands out one while the reader is ready; the head is registered.
// ----------------------------------------------------------------------------
module ppm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppm_pkg::res_t wr0_i,
  input  wire logic          wr0_vld_i,
  input  wire ppm_pkg::res_t wr1_i,
  input  wire logic          wr1_vld_i,
  output logic               room2_o,
  output ppm_pkg::res_t      rd_o,
  output logic               rd_vld_o,
  input  wire logic          rd_rdy_i
);
  import ppm_pkg::*;

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 pop;
  logic [QueuePtrW-1:0] wp1;

  assign pop      = rd_vld_o && rd_rdy_i;
  assign rd_vld_o = (cnt_q != '0);
  assign rd_o     = mem_q[rp_q];
  assign room2_o  = (cnt_q <= (QueuePtrW + 1)'(QueueDepth - 2));
  assign wp1      = wr0_vld_i ? wp_q + QueuePtrW'(1) : wp_q;

  always_comb begin
    wp_d  = wp_q + QueuePtrW'(wr0_vld_i) + QueuePtrW'(wr1_vld_i);
    rp_d  = rp_q + QueuePtrW'(pop);
    cnt_d = cnt_q + (QueuePtrW + 1)'(wr0_vld_i) + (QueuePtrW + 1)'(wr1_vld_i)
            - (QueuePtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr0_vld_i) mem_q[wp_q] <= wr0_i;
    if (wr1_vld_i) mem_q[wp1]  <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : ppm_queue
`default_nettype wire

// File: rtl/ppm_p6_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: the words a byte makes are written into the result queue when the byte
// is taken; a second (status) word from the same byte follows the first one out.
// Throughput: one byte per cycle; a byte is taken whenever the four-entry
// result queue has room for two words, so the port only stalls on back pressure.
// Reset: rst_ni clears the parser to expect the magic token and empties the
// queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_unit: streaming binary PPM (P6) parser
// The front end parses the header and classifies each byte; header, pixel
// and status words go into a small queue that drives the output port.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               byte_in_i,
  input  wire logic                     end_of_file_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    pixel_byte_o,
  output logic [ppm_pkg::DimW-1:0]      image_width_o,
  output logic [ppm_pkg::DimW-1:0]      image_height_o,
  output logic [3:0]                    status_o,
  output logic                          final_res_o
);
  import ppm_pkg::*;

  logic            take;
  logic            room2;
  res_t            r0, r1, head;
  logic            r0_vld, r1_vld;
  logic [DimW-1:0] wid, hgt;

  // A byte makes at most two words, so two free entries admit it.
  assign in_ready_o = room2;
  assign take       = in_valid_i && in_ready_o;

  ppm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .byte_i     (byte_in_i),
    .eof_i      (end_of_file_i),
    .res0_o     (r0),
    .res0_vld_o (r0_vld),
    .res1_o     (r1),
    .res1_vld_o (r1_vld),
    .width_o    (wid),
    .height_o   (hgt)
  );

  ppm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr0_i     (r0),
    .wr0_vld_i (r0_vld),
    .wr1_i     (r1),
    .wr1_vld_i (r1_vld),
    .room2_o   (room2),
    .rd_o      (head),
    .rd_vld_o  (out_valid_o),
    .rd_rdy_i  (out_ready_i)
  );

  assign kind_o         = head.kind;
  assign pixel_byte_o   = head.pixel_byte;
  assign image_width_o  = head.image_width;
  assign image_height_o = head.image_height;
  assign status_o       = head.status;
  assign final_res_o    = head.final_res;

`ifndef ASSERT_OFF
  // Only a status word closes the stream.
  a_final_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_res_o |-> kind_o == KIND_STATUS)
    else $error("final word is not a status word");

  // Words are only written while a byte is taken.
  a_write_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r0_vld || r1_vld) |-> take)
    else $error("result written without a byte");

  // A second word is always a status word.
  a_second_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_vld |-> r1.kind == KIND_STATUS && r1.final_res)
    else $error("second word is not the status word");

  // The header word reports the stored dimensions.
  a_header_dims : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r0_vld && r0.kind == KIND_HEADER |-> r0.image_width == wid && r0.image_height == hgt)
    else $error("header word dimensions mismatch");
`endif

endmodule : ppm_p6_stream_parser_unit
`default_nettype wire

// File: verif/ppm_p6_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_checker: P6 parser scoreboard
// Watches both ports, runs a cycle-free model of the parser and compares
// every result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module ppm_p6_stream_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [7:0]                 byte_in_i,
  input  logic                       end_of_file_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 pixel_byte_i,
  input  logic [ppm_pkg::DimW-1:0]   image_width_i,
  input  logic [ppm_pkg::DimW-1:0]   image_height_i,
  input  logic [3:0]                 status_i,
  input  logic                       final_res_i,
  output int                         fails_o,
  output int                         pending_o
);
  import ppm_pkg::*;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] Ch2    = 8'h32;
  localparam logic [7:0] Ch5    = 8'h35;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChNl   = 8'h0a;

  phase_e   ph;
  bit       in_cmt;
  int       tok_len;
  bit       tok_ok;
  int       num_acc;
  int       hdr_cnt;
  int       cmt_len;
  int       w_val;
  int       h_val;
  longint   pix_left;
  status_e  err_code;
  res_t     expected_words[$];

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_token();
    tok_len = 0;
    tok_ok  = 1'b1;
    num_acc = 0;
  endfunction

  function automatic void parser_reset();
    ph       = PH_MAGIC;
    in_cmt   = 1'b0;
    clear_token();
    hdr_cnt  = 0;
    cmt_len  = 0;
    w_val    = 0;
    h_val    = 0;
    pix_left = 0;
    err_code = ST_OK;
  endfunction

  function automatic void push_word(kind_e k, logic [7:0] p, int w, int h, status_e s,
                                    bit f);
    res_t r;
    r.kind         = k;
    r.pixel_byte   = p;
    r.image_width  = w[DimW-1:0];
    r.image_height = h[DimW-1:0];
    r.status       = s;
    r.final_res    = f;
    expected_words.insert(expected_words.size(), r);
  endfunction

  // Counts one header byte; true once the header limit is passed.
  function automatic bit count_hdr_byte();
    hdr_cnt++;
    return hdr_cnt > HdrLimit;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (ph == PH_MAGIC) begin
      if (!(tok_len < 2 && c == (tok_len == 0 ? ChP : Ch6))) tok_ok = 1'b0;
    end else if (ph == PH_MAXVAL) begin
      if (!(tok_len < 3 && c == (tok_len == 0 ? Ch2 : Ch5))) tok_ok = 1'b0;
    end else if (c >= Ch0 && c <= Ch9) begin
      num_acc = num_acc * 10 + int'(c - Ch0);
      if (num_acc > MaxDim) num_acc = MaxDim + 1;
    end else begin
      tok_ok = 1'b0;
    end
    tok_len++;
  endfunction

  function automatic status_e judge_token();
    if (ph == PH_MAGIC) return (tok_ok && tok_len == 2) ? ST_OK : ST_NOT_P6;
    if (ph == PH_MAXVAL) return (tok_ok && tok_len == 3) ? ST_OK : ST_BAD_MAXVAL;
    if (!tok_ok || num_acc < 1 || num_acc > MaxDim) return ST_BAD_DIM;
    if (ph == PH_WIDTH) w_val = num_acc;
    else h_val = num_acc;
    return ST_OK;
  endfunction

  function automatic status_e parse_hdr_byte(logic [7:0] c);
    status_e e;
    if (in_cmt) begin
      if (count_hdr_byte()) return ST_HDR_LONG;
      if (c == ChNl) in_cmt = 1'b0;
      else begin
        if (cmt_len == CmtLimit) return ST_CMT_LONG;
        cmt_len++;
      end
      return ST_OK;
    end
    if (tok_len == 0) begin
      if (count_hdr_byte()) return ST_HDR_LONG;
      if (c == ChHash) begin
        in_cmt  = 1'b1;
        cmt_len = 1;
      end else if (!is_ws(c)) begin
        add_char(c);
      end
      return ST_OK;
    end
    if (is_ws(c)) begin
      e = judge_token();
      if (e != ST_OK) return e;
      if (ph == PH_MAXVAL) begin
        // The separator: report the header and open the pixel window.
        push_word(KIND_HEADER, 8'd0, w_val, h_val, ST_OK, 1'b0);
        pix_left = longint'(w_val) * h_val * 3;
        ph       = PH_PIXELS;
        return ST_OK;
      end
      ph = phase_e'(ph + 1);
      clear_token();
      return count_hdr_byte() ? ST_HDR_LONG : ST_OK;
    end
    if (tok_len >= TokenMax) return ST_TOK_LONG;
    if (count_hdr_byte()) return ST_HDR_LONG;
    add_char(c);
    return ST_OK;
  endfunction

  function automatic void predict_byte(logic [7:0] c, bit eof);
    status_e e;
    e = ST_OK;
    if (ph <= PH_MAXVAL) begin
      e = parse_hdr_byte(c);
    end else if (ph == PH_PIXELS) begin
      if (pix_left > 0) begin
        push_word(KIND_PIXEL, c, 0, 0, ST_OK, 1'b0);
        pix_left--;
      end else begin
        e = ST_LEN_MISMATCH;
      end
    end
    if (e != ST_OK) begin
      err_code = e;
      ph       = PH_FAILED;
    end
    if (eof) begin
      if (ph <= PH_MAXVAL) begin
        // The pending token is judged first; a good maxval means no separator.
        if (tok_len > 0 && !in_cmt) begin
          e = judge_token();
          if (e == ST_OK) e = (ph == PH_MAXVAL) ? ST_NO_SEP : ST_INCOMPLETE;
        end else begin
          e = ST_INCOMPLETE;
        end
        err_code = e;
      end else if (ph == PH_PIXELS && pix_left != 0) begin
        err_code = ST_LEN_MISMATCH;
      end
      push_word(KIND_STATUS, 8'd0, 0, 0, err_code, 1'b1);
      parser_reset();
    end
  endfunction

  task automatic compare_word();
    res_t r;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: kind %0d", kind_i);
      fails_o++;
      return;
    end
    r = expected_words.pop_front();
    if (kind_i !== r.kind) begin
      $error("kind: expected %0d, got %0d", r.kind, kind_i);
      fails_o++;
    end
    if (pixel_byte_i !== r.pixel_byte) begin
      $error("pixel_byte: expected %0d, got %0d", r.pixel_byte, pixel_byte_i);
      fails_o++;
    end
    if (image_width_i !== r.image_width) begin
      $error("image_width: expected %0d, got %0d", r.image_width, image_width_i);
      fails_o++;
    end
    if (image_height_i !== r.image_height) begin
      $error("image_height: expected %0d, got %0d", r.image_height, image_height_i);
      fails_o++;
    end
    if (status_i !== r.status) begin
      $error("status: expected %0d, got %0d", r.status, status_i);
      fails_o++;
    end
    if (final_res_i !== r.final_res) begin
      $error("final_res: expected %0d, got %0d", r.final_res, final_res_i);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fails_o = 0;
      parser_reset();
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_word();
      if (in_valid_i && in_ready_i) predict_byte(byte_in_i, end_of_file_i);
    end
    pending_o = expected_words.size();
  end

endmodule

// File: verif/tb_ppm_p6_stream_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_p6_stream_parser_unit: regression for the P6 stream parser
// Feeds directed and random PPM files, mostly well formed with random sizes,
// comments and pixel data, some truncated, padded or corrupted, under several
// idle and back-pressure mixes. A separate checker predicts every word.
// ----------------------------------------------------------------------------
module tb_ppm_p6_stream_parser_unit;
  import ppm_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandomWords = 900;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        byte_in_i = 8'd0;
  logic              end_of_file_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        pixel_byte_o;
  logic [DimW-1:0]   image_width_o;
  logic [DimW-1:0]   image_height_o;
  logic [3:0]        status_o;
  logic              final_res_o;

  int fails;
  int pending;
  int cycles = 0;
  int words_sent = 0;
  // Percent chance per cycle that the sender idles or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  // Bumping this asks the receiver for one long hold-off.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk_i = ~clk_i;

  ppm_p6_stream_parser_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_in_i, .end_of_file_i,
    .out_valid_o, .out_ready_i, .kind_o, .pixel_byte_o, .image_width_o,
    .image_height_o, .status_o, .final_res_o
  );

  ppm_p6_stream_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .byte_in_i, .end_of_file_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .pixel_byte_i(pixel_byte_o), .image_width_i(image_width_o),
    .image_height_i(image_height_o), .status_i(status_o), .final_res_i(final_res_o),
    .fails_o(fails), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ppm_p6_stream_parser_unit regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one word and returns once it has been taken. Valid is only ever
  // assigned once per edge, so back-to-back words keep it high.
  task automatic send_word(logic [7:0] b, bit eof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    byte_in_i     <= b;
    end_of_file_i <= eof;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    words_sent++;
  endtask

  // Sends a whole file; the flag rides on the last byte.
  task automatic send_file(ref logic [7:0] f[$]);
    foreach (f[i]) send_word(f[i], i == f.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic void add_text(ref logic [7:0] f[$], input string s);
    for (int i = 0; i < s.len(); i++) f.insert(f.size(), s[i]);
  endfunction

  function automatic logic [7:0] rand_ws();
    int k;
    k = $urandom_range(6);
    return (k == 6) ? 8'd32 : 8'(9 + k % 5);
  endfunction

  // Whitespace run, sometimes with a comment whose body is any byte but newline.
  function automatic void add_gap(ref logic [7:0] f[$]);
    logic [7:0] c;
    int n;
    n = $urandom_range(1, 3);
    repeat (n) f.insert(f.size(), rand_ws());
    if ($urandom_range(4) == 0) begin
      f.insert(f.size(), "#");
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(255));
        f.insert(f.size(), c == 8'h0a ? 8'h00 : c);
      end
      f.insert(f.size(), 8'h0a);
      if ($urandom_range(1)) f.insert(f.size(), rand_ws());
    end
  endfunction

  function automatic void add_dim(ref logic [7:0] f[$], input int d);
    if ($urandom_range(5) == 0) f.insert(f.size(), "0");
    add_text(f, $sformatf("%0d", d));
  endfunction

  // Well-formed file with small dimensions, then an optional corruption, or random bytes.
  task automatic random_file();
    logic [7:0] f[$];
    int w, h, mode, pos;
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    mode = $urandom_range(99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 20)) f.insert(f.size(), 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) add_gap(f);
      add_text(f, "P6");
      add_gap(f);
      add_dim(f, w);
      add_gap(f);
      add_dim(f, h);
      add_gap(f);
      add_text(f, "255");
      f.insert(f.size(), rand_ws());
      repeat (w * h * 3) f.insert(f.size(), 8'($urandom_range(255)));
      if (mode < 16) begin
        pos = $urandom_range(f.size() - 1);
        f[pos] = 8'($urandom_range(255));
      end else if (mode < 24) begin
        f = f[0:$urandom_range(f.size() - 1)];
      end else if (mode < 30) begin
        repeat ($urandom_range(1, 3)) f.insert(f.size(), 8'($urandom_range(255)));
      end
    end
    send_file(f);
  endtask

  task automatic directed_file(string s, int pixels);
    logic [7:0] f[$];
    add_text(f, s);
    repeat (pixels) f.insert(f.size(), 8'($urandom_range(255)));
    send_file(f);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files covering most status codes and the boundary values.
    directed_file("P6 1 1 255\n", 3);
    directed_file("P6\t#c\n0001\r1\v255\f", 3);
    directed_file("P6 1 1 255 ", 0);              // header and end together
    directed_file("P6 1 1 255 ", 4);              // extra pixel byte
    directed_file("P6 2 1 255 ", 2);              // short pixel data
    directed_file("P5 ", 0);
    directed_file("P6 0 ", 0);
    directed_file("P6 4097 1", 0);
    directed_file("P6 1#2 1", 0);                  // hash inside a token
    directed_file("P6 1 1 256 ", 0);
    directed_file("P6 1 1 255", 0);                // maxval but no separator
    directed_file("P6 1 1", 0);
    directed_file("P6 1 #open", 0);
    directed_file("P6 4096 4096 255 ", 1);
    directed_file("P6 123456789012345678901234567890123", 0);
    directed_file("255\xff\x80\x7f\x00", 0);
    drain();

    // Fill the output queue with the receiver held off.
    hold_req <= hold_req + 1;
    directed_file("P6 4 4 255\n", 48);
    drain();

    words_sent = 0;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 75 : (p == 3) ? 10 : 0;
      stall_pct = (p == 2) ? 75 : (p == 3) ? 10 : 0;
      while (words_sent < (p + 1) * RandomWords / 4) random_file();
      drain();
    end

    in_valid_i <= 1'b0;
    repeat (20) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("ppm_p6_stream_parser_unit regression: pass");
    end else begin
      $display("ppm_p6_stream_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
